// File: rtl/core/dsf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package dsf_pkg;

   localparam logic [7:0] SYM_DLE = 8'h10;
   localparam logic [7:0] SYM_STX = 8'h02;
   localparam logic [7:0] SYM_ETX = 8'h03;

   // positions of one output byte within the run caused by one payload byte
   typedef enum logic [2:0] {
      SLOT_HDR_DLE,
      SLOT_HDR_STX,
      SLOT_STUFF,
      SLOT_DATA,
      SLOT_TR_DLE,
      SLOT_TR_ETX,
      SLOT_BCC
   } slot_type;

   // payload byte held while its run of line bytes goes out
   typedef struct packed {
      logic [7:0] data;
      logic       ends;
      logic       opens;
      logic [7:0] bcc;
   } item_type;

   typedef struct packed {
      logic [7:0] line_byte;
      logic       run_last;
      logic       frame_done;
      slot_type   next_slot;
   } slot_out_type;

endpackage

`default_nettype wire

// File: rtl/core/dsf_req_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface dsf_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] payload_byte;
   logic       frame_end;

   modport source (output valid, output payload_byte, output frame_end, input ready);
   modport sink (input valid, input payload_byte, input frame_end, output ready);
endinterface

`default_nettype wire

// File: rtl/core/dsf_rsp_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface dsf_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] line_byte;
   logic       run_last;
   logic       frame_done;

   modport source (output valid, output line_byte, output run_last, output frame_done,
                   input ready);
   modport sink (input valid, input line_byte, input run_last, input frame_done,
                 output ready);
endinterface

`default_nettype wire

// File: rtl/core/dle_stuffing_framer_with_bcc.sv
`timescale 1ns / 1ps
`default_nettype none

// channel  dir  transaction
// req_ch   in   payload_byte[7:0], frame_end
// rsp_ch   out  line_byte[7:0], run_last, frame_done
//
// one line byte leaves per cycle unless rsp_ch stalls; a payload byte causes 1 to 7
// line bytes (header, stuffed DLE, data, trailer), set by the slot sequencer
// the next payload byte is taken in the cycle its predecessor's last line byte
// moves to the output register, so plain data bytes flow at one per cycle
// reset is synchronous and clears the frame state, holding and output valid
// a stall on rsp_ch holds the output register and the sequencer in place

module dle_stuffing_framer_with_bcc (
   input  logic       clock,
   input  logic       reset,
   dsf_req_if.sink    req_ch,
   dsf_rsp_if.source  rsp_ch
);
   import dsf_pkg::*;

   item_type     item_ff, item_in;
   logic         item_valid_ff, item_valid_in;
   slot_type     slot_ff, slot_in;
   logic         inside_ff, inside_in;
   logic [7:0]   check_ff, check_in;
   logic         rsp_valid_ff, rsp_valid_in;
   logic [7:0]   line_byte_ff;
   logic         run_last_ff;
   logic         frame_done_ff;
   slot_out_type sel;
   logic         out_load;
   logic         req_ready;
   logic         req_accept;
   logic [7:0]   check_new;

   dsf_slot_sel u_slot_sel (
      .item_in (item_ff),
      .slot_in (slot_ff),
      .sel_out (sel)
   );

   assign out_load   = item_valid_ff && (!rsp_valid_ff || rsp_ch.ready);
   assign req_ready  = !item_valid_ff || (out_load && sel.run_last);
   assign req_accept = req_ch.valid && req_ready;
   assign check_new  = (inside_ff ? check_ff : 8'h00) ^ req_ch.payload_byte;

   always_comb begin
      item_valid_in = item_valid_ff;
      slot_in       = slot_ff;
      inside_in     = inside_ff;
      check_in      = check_ff;
      rsp_valid_in  = rsp_valid_ff;
      item_in       = item_ff;

      if (out_load) begin
         rsp_valid_in = 1'b1;
         slot_in      = sel.next_slot;
         if (sel.run_last)
            item_valid_in = 1'b0;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end

      if (req_accept) begin
         item_valid_in = 1'b1;
         item_in.data  = req_ch.payload_byte;
         item_in.ends  = req_ch.frame_end;
         item_in.opens = !inside_ff;
         item_in.bcc   = check_new ^ SYM_ETX;
         if (!inside_ff)
            slot_in = SLOT_HDR_DLE;
         else if (req_ch.payload_byte == SYM_DLE)
            slot_in = SLOT_STUFF;
         else
            slot_in = SLOT_DATA;
         inside_in = !req_ch.frame_end;
         check_in  = req_ch.frame_end ? 8'h00 : check_new;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         inside_ff     <= 1'b0;
         check_ff      <= 8'h00;
         slot_ff       <= SLOT_DATA;
      end else begin
         item_valid_ff <= item_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         inside_ff     <= inside_in;
         check_ff      <= check_in;
         slot_ff       <= slot_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
      if (out_load) begin
         line_byte_ff  <= sel.line_byte;
         run_last_ff   <= sel.run_last;
         frame_done_ff <= sel.frame_done;
      end
   end

   assign req_ch.ready      = req_ready;
   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.line_byte  = line_byte_ff;
   assign rsp_ch.run_last   = run_last_ff;
   assign rsp_ch.frame_done = frame_done_ff;

`ifndef NO_ASSERTIONS
   a_done_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && frame_done_ff |-> run_last_ff)
      else $error("check byte not marked as end of run");

   a_accept_only_at_run_end: assert property (@(posedge clock) disable iff (reset)
      req_accept && item_valid_ff |-> out_load && sel.run_last)
      else $error("new transaction taken before run finished");

   a_header_only_on_open: assert property (@(posedge clock) disable iff (reset)
      item_valid_ff && (slot_ff == SLOT_HDR_DLE || slot_ff == SLOT_HDR_STX)
      |-> item_ff.opens)
      else $error("header emitted inside a frame");

   a_reset_closes_frame: assert property (@(posedge clock)
      $past(reset) |-> !inside_ff && !item_valid_ff && !rsp_valid_ff)
      else $error("state not cleared by reset");
`endif

endmodule

`default_nettype wire

// File: rtl/core/dsf_slot_sel.sv
`timescale 1ns / 1ps
`default_nettype none

module dsf_slot_sel (
   input  dsf_pkg::item_type     item_in,
   input  dsf_pkg::slot_type     slot_in,
   output dsf_pkg::slot_out_type sel_out
);
   import dsf_pkg::*;

   logic stuff;

   assign stuff = (item_in.data == SYM_DLE);

   always_comb begin
      sel_out.line_byte  = item_in.data;
      sel_out.run_last   = 1'b0;
      sel_out.frame_done = 1'b0;
      sel_out.next_slot  = SLOT_DATA;
      unique case (slot_in)
         SLOT_HDR_DLE: begin
            sel_out.line_byte = SYM_DLE;
            sel_out.next_slot = SLOT_HDR_STX;
         end
         SLOT_HDR_STX: begin
            sel_out.line_byte = SYM_STX;
            sel_out.next_slot = stuff ? SLOT_STUFF : SLOT_DATA;
         end
         SLOT_STUFF: begin
            sel_out.line_byte = SYM_DLE;
            sel_out.next_slot = SLOT_DATA;
         end
         SLOT_DATA: begin
            sel_out.line_byte = item_in.data;
            sel_out.run_last  = !item_in.ends;
            sel_out.next_slot = SLOT_TR_DLE;
         end
         SLOT_TR_DLE: begin
            sel_out.line_byte = SYM_DLE;
            sel_out.next_slot = SLOT_TR_ETX;
         end
         SLOT_TR_ETX: begin
            sel_out.line_byte = SYM_ETX;
            sel_out.next_slot = SLOT_BCC;
         end
         SLOT_BCC: begin
            // trailer bytes are never stuffed
            sel_out.line_byte  = item_in.bcc;
            sel_out.run_last   = 1'b1;
            sel_out.frame_done = 1'b1;
            sel_out.next_slot  = SLOT_DATA;
         end
         default: begin
            sel_out.line_byte = item_in.data;
            sel_out.next_slot = SLOT_DATA;
         end
      endcase
   end

endmodule

`default_nettype wire
